// ----- rtl/upd_pkg.sv -----
// ----------------------------------------------------------------------------
// upd_pkg
// Types, codes and helpers shared by the URL path decoder/sanitizer.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] CTRL_LIMIT  = 8'h20;
  localparam logic [7:0] DEL_CODE    = 8'h7F;
  localparam logic [7:0] PCT_CODE    = 8'h25;
  localparam logic [7:0] BSLASH_CODE = 8'h5C;
  localparam logic [7:0] COLON_CODE  = 8'h3A;
  localparam logic [7:0] SLASH_CODE  = 8'h2F;
  localparam logic [7:0] DOT_CODE    = 8'h2E;
  localparam logic [3:0] ALPHA_OFFSET = 4'd10;

  // escape phase codes
  localparam logic [1:0] PH_PLAIN = 2'd0;
  localparam logic [1:0] PH_HEX1  = 2'd1;
  localparam logic [1:0] PH_HEX2  = 2'd2;

  // segment kind codes
  localparam logic [1:0] SEG_EMPTY    = 2'd0;
  localparam logic [1:0] SEG_ONE_DOT  = 2'd1;
  localparam logic [1:0] SEG_TWO_DOTS = 2'd2;
  localparam logic [1:0] SEG_OTHER    = 2'd3;

  typedef struct packed {
    logic [1:0] escape_phase;
    logic [3:0] high_nibble;
    logic [1:0] segment_kind;
    logic       forbidden_flag;
  } state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       is_final;
    logic       verdict;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } nibble_t;

  function automatic nibble_t hex_nibble(input logic [7:0] c);
    nibble_t n;
    n.ok    = 1'b1;
    n.value = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      n.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      n.value = c[3:0] - 4'd1 + ALPHA_OFFSET;
    end else begin
      n.ok = 1'b0;
    end
    return n;
  endfunction

  function automatic logic bad_byte(input logic [7:0] c);
    return c == BSLASH_CODE || c == COLON_CODE || c < CTRL_LIMIT || c == DEL_CODE;
  endfunction

endpackage

// ----- rtl/upd_if.sv -----
// ----------------------------------------------------------------------------
// upd_path_if / upd_result_if
// Valid/ready channels for raw path bytes and decoded results.
// ----------------------------------------------------------------------------
interface upd_path_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_byte;
  logic       is_last;

  modport source (output valid, path_byte, is_last, input ready);
  modport sink   (input valid, path_byte, is_last, output ready);
endinterface

interface upd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       is_final;
  logic       verdict;

  modport source (output valid, out_byte, out_valid, is_final, verdict, input ready);
  modport sink   (input valid, out_byte, out_valid, is_final, verdict, output ready);
endinterface

// ----- rtl/upd_step.sv -----
// ----------------------------------------------------------------------------
// upd_step
// Per-byte decode, check and segment tracking; next state and result.
// ----------------------------------------------------------------------------
module upd_step (
  input  upd_pkg::state_t  state,
  input  logic [7:0]       path_byte,
  input  logic             is_last,
  output upd_pkg::state_t  state_next,
  output upd_pkg::result_t result
);

  upd_pkg::nibble_t nib;
  upd_pkg::state_t  st;
  logic [7:0]       dec_byte;
  logic             dec_valid;
  logic             dot_seg;

  assign nib = upd_pkg::hex_nibble(path_byte);

  always_comb begin
    st        = state;
    dec_byte  = 8'd0;
    dec_valid = 1'b0;

    unique case (state.escape_phase)
      upd_pkg::PH_PLAIN: begin
        if (path_byte == upd_pkg::PCT_CODE) begin
          st.escape_phase = upd_pkg::PH_HEX1;
        end else begin
          dec_byte  = path_byte;
          dec_valid = 1'b1;
        end
      end
      upd_pkg::PH_HEX1: begin
        if (!nib.ok) begin
          st.forbidden_flag = 1'b1;
          st.escape_phase   = upd_pkg::PH_PLAIN;
        end else begin
          st.high_nibble  = nib.value;
          st.escape_phase = upd_pkg::PH_HEX2;
        end
      end
      default: begin
        st.escape_phase = upd_pkg::PH_PLAIN;
        if (!nib.ok) begin
          st.forbidden_flag = 1'b1;
        end else begin
          dec_byte  = {state.high_nibble, nib.value};
          dec_valid = 1'b1;
        end
      end
    endcase

    if (dec_valid) begin
      if (upd_pkg::bad_byte(dec_byte)) st.forbidden_flag = 1'b1;
      if (dec_byte == upd_pkg::SLASH_CODE) begin
        if (state.segment_kind == upd_pkg::SEG_ONE_DOT ||
            state.segment_kind == upd_pkg::SEG_TWO_DOTS) st.forbidden_flag = 1'b1;
        st.segment_kind = upd_pkg::SEG_EMPTY;
      end else if (dec_byte == upd_pkg::DOT_CODE) begin
        if (state.segment_kind == upd_pkg::SEG_EMPTY) begin
          st.segment_kind = upd_pkg::SEG_ONE_DOT;
        end else if (state.segment_kind == upd_pkg::SEG_ONE_DOT) begin
          st.segment_kind = upd_pkg::SEG_TWO_DOTS;
        end else begin
          st.segment_kind = upd_pkg::SEG_OTHER;
        end
      end else begin
        st.segment_kind = upd_pkg::SEG_OTHER;
      end
    end

    dot_seg = st.segment_kind == upd_pkg::SEG_ONE_DOT ||
              st.segment_kind == upd_pkg::SEG_TWO_DOTS;
    // end of path: open escape or trailing dot segment rejects
    if (is_last && (st.escape_phase != upd_pkg::PH_PLAIN || dot_seg)) begin
      st.forbidden_flag = 1'b1;
    end

    result.out_byte  = dec_byte;
    result.out_valid = dec_valid;
    result.is_final  = is_last;
    result.verdict   = st.forbidden_flag;

    // a new path starts after the last byte
    if (is_last) begin
      state_next = '0;
    end else begin
      state_next = st;
    end
  end

endmodule

// ----- rtl/url_path_percent_decode_sanitizer.sv -----
// ----------------------------------------------------------------------------
// url_path_percent_decode_sanitizer
// Streaming %HH decoder for request paths with a sticky forbidden verdict.
// ----------------------------------------------------------------------------
// Usage:
//   path   : raw path bytes, one item per byte, is_last on the final byte.
//   result : one item per path item: decoded byte (out_valid marks a real
//            byte), is_final copied from is_last, and the verdict so far.
//            The verdict on the is_final item is the one that counts; a
//            consumer drops the decoded bytes of a forbidden path.
//   Path items pass through an input register, then a result register.
//   Throughput: one item per cycle while result.ready stays high; the
//   per-byte state update in upd_step is combinational.
//   Reset: empties both registers and returns the decoder to the start of
//   a new path. After an is_last item the decoder also starts a new path.
//   When result.ready is low the result register holds, the input register
//   holds behind it, and path.ready drops once both are full.
// ----------------------------------------------------------------------------
module url_path_percent_decode_sanitizer (
  input  logic clk,
  input  logic rst,
  upd_path_if.sink     path,
  upd_result_if.source result
);

  logic                 in_full;
  logic [7:0]           in_byte;
  logic                 in_last;
  logic                 res_full;
  upd_pkg::result_t     res;
  upd_pkg::state_t      state;
  upd_pkg::state_t      state_next;
  upd_pkg::result_t     step_res;
  logic                 res_load;
  logic                 in_load;

  assign res_load   = in_full && (!res_full || result.ready);
  assign path.ready = !in_full || res_load;
  assign in_load    = path.valid && path.ready;

  upd_step u_step (
    .state      (state),
    .path_byte  (in_byte),
    .is_last    (in_last),
    .state_next (state_next),
    .result     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      res_full <= 1'b0;
      state    <= '0;
    end else begin
      if (in_load) begin
        in_full <= 1'b1;
      end else if (res_load) begin
        in_full <= 1'b0;
      end
      if (res_load) begin
        res_full <= 1'b1;
        state    <= state_next;
      end else if (result.ready) begin
        res_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_byte <= path.path_byte;
      in_last <= path.is_last;
    end
    if (res_load) begin
      res <= step_res;
    end
  end

  assign result.valid     = res_full;
  assign result.out_byte  = res.out_byte;
  assign result.out_valid = res.out_valid;
  assign result.is_final  = res.is_final;
  assign result.verdict   = res.verdict;

endmodule
